/* sv/cht_pkg.sv */
// ----------------------------------------------------------------------------
// cht_pkg
// Shared sizes, codes and request types of the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

    // pool and bucket sizing
    localparam int POOL_NODES  = 256;
    localparam int MAX_BUCKETS = 64;
    localparam int NODE_W      = $clog2(POOL_NODES);
    localparam int STORE_W     = $clog2(POOL_NODES + 1);
    localparam int BKT_W       = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int DIV_W       = BKT_W + 1;

    // free node search: groups of nodes, then a node inside the group
    localparam int GRP_W       = NODE_W / 2;
    localparam int BIT_W       = NODE_W - GRP_W;
    localparam int NUM_GRP     = 1 << GRP_W;
    localparam int GRP_SIZE    = 1 << BIT_W;

    // fixed field widths
    localparam int KEY_W       = 31;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 9;
    localparam int BCNT_W      = 7;
    localparam int STEP_W      = $clog2(KEY_W);
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 16;
    localparam logic [BCNT_W-1:0] BCNT_RESET = BCNT_W'(64);

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // link pointer with a valid mark
    typedef struct packed {
        logic              ok;
        logic [NODE_W-1:0] idx;
    } ptr_t;

    // classified request handed from front to back
    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [BKT_W-1:0] bucket;
    } job_t;

    // one result
    typedef struct packed {
        logic              empty;
        logic [COUNT_W-1:0] count;
        status_t           status;
    } res_t;

endpackage

/* sv/cht_front.sv */
// ----------------------------------------------------------------------------
// cht_front
// Accepts requests and works out the bucket with a bit-serial remainder.
// ----------------------------------------------------------------------------
module cht_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cht_pkg::op_t                  in_op,
    input  logic [cht_pkg::KEY_W-1:0]     in_key,
    input  logic [cht_pkg::BCNT_W-1:0]    bucket_count,
    output logic                          push,
    output cht_pkg::job_t                 job,
    input  logic                          q_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t                       state_reg, state_next;
    cht_pkg::op_t                  op_reg, op_next;
    logic [cht_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [cht_pkg::KEY_W-1:0]     shf_reg, shf_next;
    logic [cht_pkg::BKT_W-1:0]     rem_reg, rem_next;
    logic [cht_pkg::DIV_W-1:0]     div_reg, div_next;
    logic [cht_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [cht_pkg::DIV_W-1:0]     trial;
    logic [cht_pkg::DIV_W-1:0]     div_clamp;

    // bucket count of zero acts as one, above the maximum as the maximum
    always_comb
    begin
        priority if (bucket_count == '0)
            div_clamp = cht_pkg::DIV_W'(1);
        else if (int'(bucket_count) > cht_pkg::MAX_BUCKETS)
            div_clamp = cht_pkg::DIV_W'(cht_pkg::MAX_BUCKETS);
        else
            div_clamp = cht_pkg::DIV_W'(bucket_count);
    end

    // one remainder bit per cycle, key msb first
    assign trial = {rem_reg, shf_reg[cht_pkg::KEY_W-1]};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        shf_next   = shf_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_op;
                    key_next   = in_key;
                    shf_next   = in_key;
                    rem_next   = '0;
                    div_next   = div_clamp;
                    step_next  = cht_pkg::STEP_W'(cht_pkg::KEY_W - 1);
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (trial >= div_reg)
                    rem_next = cht_pkg::BKT_W'(trial - div_reg);
                else
                    rem_next = cht_pkg::BKT_W'(trial);
                shf_next = shf_reg << 1;
                if (step_reg == '0)
                    state_next = F_PUSH;
                else
                    step_next = step_reg - 1'b1;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    assign in_ready   = (state_reg == F_IDLE);
    assign job.op     = op_reg;
    assign job.key    = key_reg;
    assign job.bucket = rem_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        shf_reg  <= shf_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        step_reg <= step_next;
    end

endmodule

/* sv/cht_queue.sv */
// ----------------------------------------------------------------------------
// cht_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module cht_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cht_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output cht_pkg::job_t pop_job
);

    cht_pkg::job_t entry_reg [2];
    logic          wr_reg, wr_next;
    logic          rd_reg, rd_next;
    logic [1:0]    cnt_reg, cnt_next;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_next  = wr_reg ^ push;
        rd_next  = rd_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign pop_job = entry_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_job;
    end

endmodule

/* sv/cht_engine.sv */
// ----------------------------------------------------------------------------
// cht_engine
// Carries out requests on the bucket heads, the node pool and the chains.
// ----------------------------------------------------------------------------
module cht_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  cht_pkg::job_t q_job,
    output logic          pop,
    output logic          res_valid,
    input  logic          res_ready,
    output cht_pkg::res_t res
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_FREE_GRP = 7'b0000010,
        S_FREE_BIT = 7'b0000100,
        S_INIT     = 7'b0001000,
        S_READ     = 7'b0010000,
        S_CHECK    = 7'b0100000,
        S_HEAD     = 7'b1000000
    } estate_t;

    estate_t                          state_reg, state_next;
    cht_pkg::job_t                    job_reg, job_next;
    logic [cht_pkg::NODE_W-1:0]       cur_reg, cur_next;
    logic [cht_pkg::NODE_W-1:0]       new_reg, new_next;
    logic [cht_pkg::GRP_W-1:0]        grp_reg, grp_next;
    logic [cht_pkg::STORE_W-1:0]      cnt_reg, cnt_next;
    logic                             out_valid_reg, out_valid_next;
    cht_pkg::res_t                    out_reg, out_next;

    // bucket heads and node pool
    logic [cht_pkg::MAX_BUCKETS-1:0]  head_ok_reg;
    logic [cht_pkg::NODE_W-1:0]       head_idx [cht_pkg::MAX_BUCKETS];
    logic [cht_pkg::BKT_W-1:0]        head_raddr;
    logic [cht_pkg::NODE_W-1:0]       head_rd;
    logic [cht_pkg::POOL_NODES-1:0]   in_use_reg;
    logic [cht_pkg::KEY_W-1:0]        key_mem [cht_pkg::POOL_NODES];
    cht_pkg::ptr_t                    nxt_mem [cht_pkg::POOL_NODES];
    cht_pkg::ptr_t                    prv_mem [cht_pkg::POOL_NODES];
    logic [cht_pkg::KEY_W-1:0]        key_rd;
    cht_pkg::ptr_t                    nxt_rd, prv_rd;

    // write controls
    logic                             head_we;
    logic [cht_pkg::BKT_W-1:0]        head_waddr;
    cht_pkg::ptr_t                    head_wdata;
    logic                             use_set, use_clr, clear_all;
    logic [cht_pkg::NODE_W-1:0]       use_addr;
    logic                             key_we;
    logic                             nxt_we, prv_we;
    logic [cht_pkg::NODE_W-1:0]       nxt_waddr, prv_waddr;
    cht_pkg::ptr_t                    nxt_wdata, prv_wdata;
    logic                             fin;
    cht_pkg::status_t                 fin_status;

    // free node search
    logic [cht_pkg::NUM_GRP-1:0]      grp_free;
    logic                             any_free;
    logic [cht_pkg::GRP_W-1:0]        grp_enc;
    logic [cht_pkg::GRP_SIZE-1:0]     grp_bits;
    logic [cht_pkg::BIT_W-1:0]        bit_enc;

    always_comb
    begin
        for (int g = 0; g < cht_pkg::NUM_GRP; g++)
            grp_free[g] = ~&in_use_reg[g*cht_pkg::GRP_SIZE +: cht_pkg::GRP_SIZE];
        any_free = |grp_free;
        grp_enc  = '0;
        for (int g = cht_pkg::NUM_GRP - 1; g >= 0; g--)
            if (grp_free[g])
                grp_enc = cht_pkg::GRP_W'(g);
    end

    // lowest free node inside the chosen group
    always_comb
    begin
        grp_bits = in_use_reg[grp_reg*cht_pkg::GRP_SIZE +: cht_pkg::GRP_SIZE];
        bit_enc  = '0;
        for (int b = cht_pkg::GRP_SIZE - 1; b >= 0; b--)
            if (!grp_bits[b])
                bit_enc = cht_pkg::BIT_W'(b);
    end

    // head pointer read address: incoming request while idle, else the current one
    assign head_raddr = (state_reg == S_IDLE) ? q_job.bucket : job_reg.bucket;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cur_next   = cur_reg;
        new_next   = new_reg;
        grp_next   = grp_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        head_we    = 1'b0;
        head_waddr = job_reg.bucket;
        head_wdata = '0;
        use_set    = 1'b0;
        use_clr    = 1'b0;
        use_addr   = new_reg;
        clear_all  = 1'b0;
        key_we     = 1'b0;
        nxt_we     = 1'b0;
        nxt_waddr  = new_reg;
        nxt_wdata  = '0;
        prv_we     = 1'b0;
        prv_waddr  = new_reg;
        prv_wdata  = '0;
        fin        = 1'b0;
        fin_status = cht_pkg::ST_DONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    pop      = 1'b1;
                    job_next = q_job;
                    unique case (q_job.op)
                        cht_pkg::OP_ADD:
                            state_next = S_FREE_GRP;
                        cht_pkg::OP_REMOVE, cht_pkg::OP_LOOKUP:
                        begin
                            if (head_ok_reg[q_job.bucket])
                                state_next = S_HEAD;
                            else
                            begin
                                fin        = 1'b1;
                                fin_status = cht_pkg::ST_MISS;
                            end
                        end
                        cht_pkg::OP_CLEAR:
                        begin
                            clear_all = 1'b1;
                            cnt_next  = '0;
                            fin       = 1'b1;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_HEAD:
            begin
                // head pointer read is back, start the chain walk
                cur_next   = head_rd;
                state_next = S_READ;
            end
            S_FREE_GRP:
            begin
                if (any_free)
                begin
                    grp_next   = grp_enc;
                    state_next = S_FREE_BIT;
                end
                else
                begin
                    fin        = 1'b1;
                    fin_status = cht_pkg::ST_FULL;
                    state_next = S_IDLE;
                end
            end
            S_FREE_BIT:
            begin
                new_next   = {grp_reg, bit_enc};
                state_next = S_INIT;
            end
            S_INIT:
            begin
                // new node starts with no links
                key_we  = 1'b1;
                nxt_we  = 1'b1;
                prv_we  = 1'b1;
                use_set = 1'b1;
                if (head_ok_reg[job_reg.bucket])
                begin
                    cur_next   = head_rd;
                    state_next = S_READ;
                end
                else
                begin
                    head_we        = 1'b1;
                    head_wdata.ok  = 1'b1;
                    head_wdata.idx = new_reg;
                    cnt_next       = cnt_reg + 1'b1;
                    fin            = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_READ:
                state_next = S_CHECK;
            S_CHECK:
            begin
                if (job_reg.op == cht_pkg::OP_ADD)
                begin
                    if (nxt_rd.ok)
                    begin
                        cur_next   = nxt_rd.idx;
                        state_next = S_READ;
                    end
                    else
                    begin
                        // append behind the tail
                        nxt_we        = 1'b1;
                        nxt_waddr     = cur_reg;
                        nxt_wdata.ok  = 1'b1;
                        nxt_wdata.idx = new_reg;
                        prv_we        = 1'b1;
                        prv_wdata.ok  = 1'b1;
                        prv_wdata.idx = cur_reg;
                        cnt_next      = cnt_reg + 1'b1;
                        fin           = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (key_rd == job_reg.key)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                    if (job_reg.op == cht_pkg::OP_REMOVE)
                    begin
                        // unlink the matching node
                        if (prv_rd.ok)
                        begin
                            nxt_we    = 1'b1;
                            nxt_waddr = prv_rd.idx;
                            nxt_wdata = nxt_rd;
                        end
                        else
                        begin
                            head_we    = 1'b1;
                            head_wdata = nxt_rd;
                        end
                        if (nxt_rd.ok)
                        begin
                            prv_we    = 1'b1;
                            prv_waddr = nxt_rd.idx;
                            prv_wdata = prv_rd;
                        end
                        use_clr  = 1'b1;
                        use_addr = cur_reg;
                        if (cnt_reg != '0)
                            cnt_next = cnt_reg - 1'b1;
                    end
                end
                else if (nxt_rd.ok)
                begin
                    cur_next   = nxt_rd.idx;
                    state_next = S_READ;
                end
                else
                begin
                    fin        = 1'b1;
                    fin_status = cht_pkg::ST_MISS;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg & ~res_ready;
        out_next       = out_reg;
        if (fin)
        begin
            out_valid_next = 1'b1;
            out_next.status = fin_status;
            out_next.count  = cht_pkg::COUNT_W'(cnt_next);
            out_next.empty  = (cnt_next == '0);
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // control state and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            head_ok_reg   <= '0;
            in_use_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (clear_all)
            begin
                head_ok_reg <= '0;
                in_use_reg  <= '0;
            end
            else
            begin
                if (head_we)
                    head_ok_reg[head_waddr] <= head_wdata.ok;
                if (use_set)
                    in_use_reg[use_addr] <= 1'b1;
                else if (use_clr)
                    in_use_reg[use_addr] <= 1'b0;
            end
        end
    end

    // datapath registers and head pointers
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        cur_reg <= cur_next;
        new_reg <= new_next;
        grp_reg <= grp_next;
        out_reg <= out_next;
        if (head_we)
            head_idx[head_waddr] <= head_wdata.idx;
        head_rd <= head_idx[head_raddr];
    end

    // node memories, read at the current node
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[new_reg] <= job_reg.key;
        if (nxt_we)
            nxt_mem[nxt_waddr] <= nxt_wdata;
        if (prv_we)
            prv_mem[prv_waddr] <= prv_wdata;
        key_rd <= key_mem[cur_reg];
        nxt_rd <= nxt_mem[cur_reg];
        prv_rd <= prv_mem[cur_reg];
    end

endmodule

/* sv/chained_hash_table.sv */
// ----------------------------------------------------------------------------
// chained_hash_table
// Key table with one doubly linked chain per bucket over a fixed node pool.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  s_*      in         request: opcode in tuser, key in tdata
//  m_*      out        result: status, item count, empty flag in tdata
//  cfg_*    in         bucket count register write
//
//  The front registers a request, forms its bucket as a bit-serial key remainder
//  and pushes it when the queue has room. The back answers clear, or a remove
//  or lookup on an empty bucket, from idle; others read the head, then each chain
//  node in turn, add after taking a free node; a two-entry queue sits between.
//  Reset clears heads and the free map at once; no clearing pass is needed.
//  A result held on m_* stalls the back; the front stops once the queue fills.
// ----------------------------------------------------------------------------
module chained_hash_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cht_pkg::IN_DATA_W-1:0]     s_tdata,   // key[30:0], pad
    input  logic [cht_pkg::OP_W-1:0]          s_tuser,   // opcode[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cht_pkg::OUT_DATA_W-1:0]    m_tdata,   // status, item_count, table_empty, pad
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cht_pkg::BCNT_W-1:0]        cfg_data
);

    logic [cht_pkg::BCNT_W-1:0] bucket_count_reg;
    logic                       push, q_full, q_valid, pop;
    cht_pkg::job_t              push_job, pop_job;
    cht_pkg::res_t              res;

    // bucket count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bucket_count_reg <= cht_pkg::BCNT_RESET;
        else if (cfg_valid)
            bucket_count_reg <= cfg_data;
    end

    cht_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (cht_pkg::op_t'(s_tuser)),
        .in_key       (s_tdata[cht_pkg::KEY_W-1:0]),
        .bucket_count (bucket_count_reg),
        .push         (push),
        .job          (push_job),
        .q_full       (q_full)
    );

    cht_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .pop_job  (pop_job)
    );

    cht_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (pop_job),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // result packing, status in the lowest bits
    assign m_tdata = cht_pkg::OUT_DATA_W'(res);

endmodule

/* sv/cht_checker.sv */
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks of the chained hash table results.
// ----------------------------------------------------------------------------
module cht_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [cht_pkg::OUT_DATA_W-1:0]    m_tdata
);

    // held result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // held result keeps its value
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // empty flag agrees with the item count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11] == (m_tdata[10:2] == 9'd0)))
        else $error("empty flag disagrees with count");

    // status is a defined code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("undefined status code");

endmodule

bind chained_hash_table cht_checker u_cht_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chained hash table: a queue-fed driver sends
// add, remove, lookup and clear requests, a software copy of the table
// predicts each result, and a monitor compares it field by field. The bucket
// count is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NIL = -1;

    typedef struct packed {
        cht_pkg::op_t              op;
        logic [cht_pkg::KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        cht_pkg::status_t            status;
        logic [cht_pkg::COUNT_W-1:0] count;
        logic                        empty;
    } exp_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [cht_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [cht_pkg::OP_W-1:0]       s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [cht_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [cht_pkg::BCNT_W-1:0]     cfg_data;

    chained_hash_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // software copy of the table
    logic [cht_pkg::BCNT_W-1:0] model_bcnt;
    int                         head_of [cht_pkg::MAX_BUCKETS];
    logic [cht_pkg::KEY_W-1:0]  key_of  [cht_pkg::POOL_NODES];
    int                         next_of [cht_pkg::POOL_NODES];
    int                         prev_of [cht_pkg::POOL_NODES];
    bit                         busy    [cht_pkg::POOL_NODES];
    int                         stored;

    req_t pending_reqs[$];
    exp_t expected_results[$];
    logic [cht_pkg::KEY_W-1:0] added_keys[$];
    req_t drv_req;
    int   mismatches;
    int   send_wait;
    int   recv_wait;

    function automatic int bucket_for(logic [cht_pkg::KEY_W-1:0] k);
        int n;
        n = model_bcnt;
        if (n == 0) n = 1;
        if (n > cht_pkg::MAX_BUCKETS) n = cht_pkg::MAX_BUCKETS;
        return k % n;
    endfunction

    function automatic void wipe_table();
        foreach (head_of[i]) head_of[i] = NIL;
        foreach (busy[i]) busy[i] = 0;
        stored = 0;
    endfunction

    function automatic int find_node(int b, logic [cht_pkg::KEY_W-1:0] k);
        int cur;
        cur = head_of[b];
        while (cur != NIL)
        begin
            if (key_of[cur] == k) return cur;
            cur = next_of[cur];
        end
        return NIL;
    endfunction

    // compute the result of one request and update the copy
    function automatic exp_t apply_request(req_t r);
        exp_t e;
        int   b;
        int   n;
        int   t;
        e.status = cht_pkg::ST_DONE;
        b = bucket_for(r.key);
        case (r.op)
            cht_pkg::OP_ADD:
            begin
                n = NIL;
                for (int i = 0; i < cht_pkg::POOL_NODES; i++)
                    if (!busy[i] && n == NIL) n = i;
                if (n == NIL) e.status = cht_pkg::ST_FULL;
                else
                begin
                    busy[n] = 1;
                    key_of[n] = r.key;
                    next_of[n] = NIL;
                    prev_of[n] = NIL;
                    if (head_of[b] == NIL) head_of[b] = n;
                    else
                    begin
                        t = head_of[b];
                        while (next_of[t] != NIL) t = next_of[t];
                        next_of[t] = n;
                        prev_of[n] = t;
                    end
                    stored++;
                end
            end
            cht_pkg::OP_REMOVE:
            begin
                t = find_node(b, r.key);
                if (t == NIL) e.status = cht_pkg::ST_MISS;
                else
                begin
                    if (prev_of[t] != NIL) next_of[prev_of[t]] = next_of[t];
                    else head_of[b] = next_of[t];
                    if (next_of[t] != NIL) prev_of[next_of[t]] = prev_of[t];
                    busy[t] = 0;
                    stored--;
                end
            end
            cht_pkg::OP_LOOKUP:
                if (find_node(b, r.key) == NIL) e.status = cht_pkg::ST_MISS;
            default:
                wipe_table();
        endcase
        e.count = stored[cht_pkg::COUNT_W-1:0];
        e.empty = (stored == 0);
        return e;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic logic [cht_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0: return cht_pkg::KEY_W'($urandom());
            1: return ($urandom_range(0, 1) ? 31'h7FFFFFC0 : 31'h0)
                      | cht_pkg::KEY_W'($urandom_range(0, 63));
            default:
                if (added_keys.size() > 0 && $urandom_range(0, 2) != 0)
                    return added_keys[$urandom_range(0, added_keys.size() - 1)];
                else return cht_pkg::KEY_W'($urandom_range(0, 300));
        endcase
    endfunction

    function automatic void queue_req(cht_pkg::op_t op, logic [cht_pkg::KEY_W-1:0] k);
        req_t r;
        r.op = op;
        r.key = k;
        pending_reqs.push_back(r);
        if (op == cht_pkg::OP_ADD) added_keys.push_back(k);
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata <= '0;
            s_tuser <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                s_tvalid <= 0;
                send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            end
            else if (!s_tvalid)
            begin
                if (send_wait > 0)
                    send_wait <= send_wait - 1;
                else if (pending_reqs.size() > 0)
                begin
                    drv_req = pending_reqs.pop_front();
                    s_tvalid <= 1;
                    s_tdata <= {1'b0, drv_req.key};
                    s_tuser <= drv_req.op;
                    expected_results.push_back(apply_request(drv_req));
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 0;
            recv_wait <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", int'(m_tdata), 0);
                else
                begin
                    exp_t e;
                    e = expected_results.pop_front();
                    if (m_tdata[1:0] != e.status)
                        report_mismatch("status", m_tdata[1:0], e.status);
                    if (m_tdata[10:2] != e.count)
                        report_mismatch("item_count", m_tdata[10:2], e.count);
                    if (m_tdata[11] != e.empty)
                        report_mismatch("table_empty", m_tdata[11], e.empty);
                end
                recv_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
                m_tready <= 0;
            end
            else if (recv_wait > 0) recv_wait <= recv_wait - 1;
            else m_tready <= 1;
        end
    end

    // config write while idle
    task automatic write_bcnt(logic [cht_pkg::BCNT_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        model_bcnt = v;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [cht_pkg::BCNT_W-1:0] settings[8];
        settings = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd7, 7'd3, 7'd16};
        mismatches = 0;
        cfg_valid = 0;
        cfg_data = '0;
        model_bcnt = cht_pkg::BCNT_RESET;
        wipe_table();
        rst_n = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, every op, misses, duplicates
        queue_req(cht_pkg::OP_LOOKUP, 31'd5);
        queue_req(cht_pkg::OP_REMOVE, 31'd5);
        queue_req(cht_pkg::OP_ADD, 31'd0);
        queue_req(cht_pkg::OP_ADD, 31'h7FFFFFFF);
        queue_req(cht_pkg::OP_ADD, 31'd64);
        queue_req(cht_pkg::OP_ADD, 31'd64);
        queue_req(cht_pkg::OP_ADD, 31'd128);
        queue_req(cht_pkg::OP_LOOKUP, 31'd128);
        queue_req(cht_pkg::OP_REMOVE, 31'd64);
        queue_req(cht_pkg::OP_LOOKUP, 31'd64);
        queue_req(cht_pkg::OP_REMOVE, 31'd64);
        queue_req(cht_pkg::OP_REMOVE, 31'd64);
        queue_req(cht_pkg::OP_LOOKUP, 31'h7FFFFFFF);
        queue_req(cht_pkg::OP_CLEAR, 31'h2AAAAAAA);
        queue_req(cht_pkg::OP_LOOKUP, 31'd0);
        drain();

        // pool full, then keys left stranded by a bucket count change
        for (int i = 0; i < cht_pkg::POOL_NODES + 3; i++)
            queue_req(cht_pkg::OP_ADD, cht_pkg::KEY_W'($urandom()));
        queue_req(cht_pkg::OP_REMOVE, added_keys[10]);
        queue_req(cht_pkg::OP_ADD, 31'd77);
        queue_req(cht_pkg::OP_ADD, 31'd78);
        drain();
        write_bcnt(7'd5);
        for (int i = 0; i < 20; i++)
            queue_req($urandom_range(0, 1) ? cht_pkg::OP_LOOKUP : cht_pkg::OP_REMOVE,
                      added_keys[$urandom_range(0, added_keys.size() - 1)]);
        queue_req(cht_pkg::OP_CLEAR, 31'd0);
        drain();

        // random phases over several bucket counts
        foreach (settings[s])
        begin
            write_bcnt(settings[s]);
            added_keys.delete();
            for (int i = 0; i < 120; i++)
            begin
                int p;
                p = $urandom_range(0, 99);
                if (p < 45) queue_req(cht_pkg::OP_ADD, pick_key());
                else if (p < 70) queue_req(cht_pkg::OP_REMOVE, pick_key());
                else if (p < 98) queue_req(cht_pkg::OP_LOOKUP, pick_key());
                else queue_req(cht_pkg::OP_CLEAR, cht_pkg::KEY_W'($urandom()));
            end
            drain();
        end
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // timeout
    initial
    begin
        #100000000;
        $display("testbench: FAIL");
        $finish;
    end
endmodule

/* files.f */
sv/cht_pkg.sv
sv/cht_front.sv
sv/cht_queue.sv
sv/cht_engine.sv
sv/chained_hash_table.sv
sv/cht_checker.sv
dv/testbench.sv
